// ===== rtl/u2da_pkg.sv =====
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package u2da_pkg;

    localparam int VALUE_WIDTH = 64;
    // Decimal digits needed for VALUE_WIDTH bits: ceil(VALUE_WIDTH * log10(2)).
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103 + 99999) / 100000;
    localparam int CONV_CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== rtl/u2da_cell.sv =====
// ----------------------------------------------------------------------------
// u2da_cell
// One BCD digit of the shift-and-add-3 chain; also shifts digits upwards
// during output.
// ----------------------------------------------------------------------------
module u2da_cell (
    input  logic                i_clk,
    input  u2da_pkg::t_cell_ctl i_ctl,
    input  logic                i_bit,
    input  logic [3:0]          i_digit,
    output logic                o_bit,
    output logic [3:0]          o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.conv) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== rtl/u64_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii
// Converts an unsigned number to decimal ASCII digits, most significant first.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  input    | start / busy     | i_value
//  result   | o_valid (strobe) | o_digit_char, o_last_digit
//
// An item enters the chain of digit cells one bit per cycle, then one digit
// per cycle leaves the top of the chain, leading zeros being dropped silently
// though the final digit always goes out.
// Synchronous active-low reset returns the controller to idle.
// The receiver cannot stall; each digit is shown for one cycle.
module u64_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value,
    output logic        o_valid,
    output logic [5:0]  o_digit_char,
    output logic        o_last_digit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int N = u2da_pkg::NUM_DIGITS;
    localparam int W = u2da_pkg::VALUE_WIDTH;

    logic [1:0]                        r_state, n_state;
    logic [W-1:0]                      r_shift, n_shift;
    logic [u2da_pkg::CONV_CNT_W-1:0]   r_conv, n_conv;
    logic [u2da_pkg::LEFT_CNT_W-1:0]   r_left, n_left;
    logic                              r_seen, n_seen;
    logic                              r_valid, n_valid;
    logic [5:0]                        r_char, n_char;
    logic                              r_last, n_last;
    u2da_pkg::t_cell_ctl               w_ctl;
    logic [N:0]                        w_bit;
    logic [3:0]                        w_dig [N+1];
    logic [3:0]                        w_top;
    logic                              w_accept;
    logic                              w_final;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign w_bit[0] = r_shift[W-1];
    assign w_dig[0] = 4'd0;
    assign w_top    = w_dig[N];
    assign w_final  = (r_left == u2da_pkg::LEFT_CNT_W'(1));

    for (genvar g = 0; g < N; g++) begin : g_cell
        u2da_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_bit[g]),
            .i_digit (w_dig[g]),
            .o_bit   (w_bit[g+1]),
            .o_digit (w_dig[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        n_shift = r_shift;
        n_conv  = r_conv;
        n_left  = r_left;
        n_seen  = r_seen;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        w_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    w_ctl.clear = 1'b1;
                    n_shift     = i_value[W-1:0];
                    n_conv      = '0;
                    n_state     = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctl.conv = 1'b1;
                n_shift    = r_shift << 1;
                n_conv     = r_conv + 1'b1;
                if (r_conv == u2da_pkg::CONV_CNT_W'(W - 1)) begin
                    n_left  = u2da_pkg::LEFT_CNT_W'(N);
                    n_seen  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                w_ctl.shift = 1'b1;
                n_left      = r_left - 1'b1;
                // Leading zeros are dropped, but the final digit always goes out.
                if (r_seen || w_top != 4'd0 || w_final) begin
                    n_seen  = 1'b1;
                    n_valid = 1'b1;
                    n_char  = {u2da_pkg::ASCII_DIGIT_HI, w_top};
                    n_last  = w_final;
                end
                if (w_final) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_seen  <= n_seen;
        end
        r_shift <= n_shift;
        r_conv  <= n_conv;
        r_left  <= n_left;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted item did not make the block busy");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_valid |-> r_state == ST_EMIT)
        else $error("digit strobe outside output phase");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char[5:4] == u2da_pkg::ASCII_DIGIT_HI
                     && o_digit_char[3:0] <= 4'd9))
        else $error("digit character out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_digit) |-> !busy)
        else $error("last digit while block still busy");

endmodule
